// File: sv/b64lw_pkg.sv
// b64lw_pkg: shared constants and the base64 alphabet for the line-wrapping encoder.
// Used by base64_encoder_line_wrap; depends on nothing else.
`default_nettype none

package b64lw_pkg;

  // Width of the output column counter (saturating)
  localparam int COLUMN_BITS = 16;
  // Width of the line width register
  localparam int LINE_W_BITS = 16;
  // Width wide enough to compare column and line width
  localparam int CMP_BITS = (COLUMN_BITS > LINE_W_BITS) ? COLUMN_BITS : LINE_W_BITS;

  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  // Byte count in the open group
  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_EMPTY = 2'd0;
  localparam phase_t PHASE_ONE   = 2'd1;
  localparam phase_t PHASE_TWO   = 2'd2;

  // Map one sextet to its standard base64 character
  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] v;
    v = {2'b00, sextet};
    if (sextet < 6'd26) begin
      return CHAR_UPPER_A + v;
    end else if (sextet < 6'd52) begin
      return CHAR_LOWER_A + v - 8'd26;
    end else if (sextet < 6'd62) begin
      return CHAR_ZERO + v - 8'd52;
    end else if (sextet == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/base64_encoder_line_wrap.sv
// base64_encoder_line_wrap: streaming base64 encoder with optional newline insertion.
// Depends on b64lw_pkg for the alphabet, character codes and counter widths.
//
// Usage:
//   Input stream: one raw byte per request on in_tdata, in_tlast marks the final
//   byte of a message. Output stream: one ASCII character per request on out_tdata,
//   out_tuser flags the last character caused by an input byte, out_tlast flags the
//   final character of the encoded message.
//   cfg_wr_en/cfg_wr_data set the line width (0 = no wrapping); write only while idle.
// Path: a group-closing byte loads the group buffer, and each of its characters then
//   passes through the output register to out_tdata; bytes inside a group give no output.
// Flow: the output register sends one character per cycle while out_tready is high, so
//   a group of three bytes occupies the buffer for its 4 characters plus any newlines.
//   The first byte of the next group is taken in the cycle the buffer's last result
//   leaves it; until then in_tready stays low, so no new byte is taken while a
//   completed group is still being sent.
// Reset: rst_n low clears the open group, column counter, line width and all valid
//   flags; no clearing pass is needed.
// Stall: when out_tready is low the output register holds its character, the group
//   buffer holds, and in_tready stays low while a completed group is waiting.
`default_nettype none

module base64_encoder_line_wrap
  import b64lw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: line width
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_char
  output logic             out_tuser,  // run_end
  output logic             out_tlast   // message_end
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [LINE_W_BITS-1:0] line_w_r;

  logic [15:0]            pend_r, pend_nxt;
  phase_t                 phase_r, phase_nxt;

  logic                   grp_valid_r, grp_valid_nxt;
  logic [3:0][7:0]        grp_chars_r, grp_chars_nxt;
  logic                   grp_final_r, grp_final_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic                   nl_pend_r, nl_pend_nxt;
  logic                   nl_end_r, nl_end_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_run_end_r, out_run_end_nxt;
  logic                   out_msg_end_r, out_msg_end_nxt;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic out_adv;
  logic step;
  logic grp_done;
  logic grp_close;

  assign out_adv   = !out_valid_r || out_tready;
  assign step      = grp_valid_r && out_adv;
  // accept while the buffer is free, or frees this cycle
  assign in_tready = !grp_valid_r || (step && grp_done);
  assign in_acc    = in_tvalid && in_tready;
  assign grp_close = (phase_r == PHASE_TWO) || in_tlast;

  // ---------------------------------------------------------------------------
  // Group assembly: collect bytes, build four characters on a closing byte
  // ---------------------------------------------------------------------------
  logic [23:0] word;

  always_comb begin
    pend_nxt      = pend_r;
    phase_nxt     = phase_r;
    word          = {pend_r, in_tdata};
    grp_chars_nxt = grp_chars_r;
    grp_final_nxt = grp_final_r;

    unique case (phase_r)
      PHASE_TWO: word = {pend_r, in_tdata};
      PHASE_ONE: word = {pend_r[15:8], in_tdata, 8'h00};
      default:   word = {in_tdata, 16'h0000};
    endcase

    if (in_acc) begin
      if (grp_close) begin
        pend_nxt         = 16'h0000;
        phase_nxt        = PHASE_EMPTY;
        grp_final_nxt    = in_tlast;
        grp_chars_nxt[0] = b64_char(word[23:18]);
        grp_chars_nxt[1] = b64_char(word[17:12]);
        grp_chars_nxt[2] = b64_char(word[11:6]);
        grp_chars_nxt[3] = b64_char(word[5:0]);
        // pad a short final group
        if (phase_r == PHASE_ONE) begin
          grp_chars_nxt[3] = CHAR_PAD;
        end else if (phase_r == PHASE_EMPTY) begin
          grp_chars_nxt[2] = CHAR_PAD;
          grp_chars_nxt[3] = CHAR_PAD;
        end
      end else if (phase_r == PHASE_EMPTY) begin
        pend_nxt  = {in_tdata, 8'h00};
        phase_nxt = PHASE_ONE;
      end else begin
        pend_nxt  = {pend_r[15:8], in_tdata};
        phase_nxt = PHASE_TWO;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Emitter: one character or newline per step, column tracking
  // ---------------------------------------------------------------------------
  logic [COLUMN_BITS-1:0] col_inc;
  logic                   is_final;
  logic                   wrap;

  assign col_inc  = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
  assign is_final = grp_final_r && (idx_r == 2'd3);
  assign wrap     = !is_final && (line_w_r != '0) &&
                    (CMP_BITS'(col_inc) >= CMP_BITS'(line_w_r));

  always_comb begin
    idx_nxt         = idx_r;
    nl_pend_nxt     = nl_pend_r;
    nl_end_nxt      = nl_end_r;
    col_nxt         = col_r;
    grp_done        = 1'b0;
    out_valid_nxt   = out_valid_r;
    out_char_nxt    = out_char_r;
    out_run_end_nxt = out_run_end_r;
    out_msg_end_nxt = out_msg_end_r;

    // drop the sent character
    if (out_adv) begin
      out_valid_nxt = 1'b0;
    end

    if (step) begin
      out_valid_nxt = 1'b1;
      if (nl_pend_r) begin
        out_char_nxt    = CHAR_NEWLINE;
        out_run_end_nxt = nl_end_r;
        out_msg_end_nxt = 1'b0;
        nl_pend_nxt     = 1'b0;
        grp_done        = nl_end_r;
      end else begin
        out_char_nxt    = grp_chars_r[idx_r];
        out_run_end_nxt = (idx_r == 2'd3) && !wrap;
        out_msg_end_nxt = is_final;
        idx_nxt         = idx_r + 2'd1;
        nl_pend_nxt     = wrap;
        nl_end_nxt      = (idx_r == 2'd3);
        grp_done        = (idx_r == 2'd3) && !wrap;
        col_nxt         = (is_final || wrap) ? '0 : col_inc;
      end
    end
  end

  // buffer occupancy: load on a closing byte, release after its last result
  always_comb begin
    grp_valid_nxt = grp_valid_r;
    if (step && grp_done) begin
      grp_valid_nxt = 1'b0;
    end
    if (in_acc && grp_close) begin
      grp_valid_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_w_r    <= '0;
      phase_r     <= PHASE_EMPTY;
      pend_r      <= '0;
      grp_valid_r <= 1'b0;
      idx_r       <= '0;
      nl_pend_r   <= 1'b0;
      nl_end_r    <= 1'b0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_w_r <= cfg_wr_data;
      end
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      grp_valid_r <= grp_valid_nxt;
      idx_r       <= idx_nxt;
      nl_pend_r   <= nl_pend_nxt;
      nl_end_r    <= nl_end_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    grp_chars_r   <= grp_chars_nxt;
    grp_final_r   <= grp_final_nxt;
    out_char_r    <= out_char_nxt;
    out_run_end_r <= out_run_end_nxt;
    out_msg_end_r <= out_msg_end_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_run_end_r;
  assign out_tlast  = out_msg_end_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // message end always closes the run of its byte
  a_msg_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("message end without run end");

  // the final character is never a newline
  a_msg_end_not_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata != CHAR_NEWLINE)
    else $error("message ends on a newline");

  // a pending newline belongs to a live group
  a_nl_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    nl_pend_r |-> grp_valid_r)
    else $error("newline pending with empty group buffer");

  // a newline is emitted only when wrapping is enabled
  a_nl_needs_width: assert property (@(posedge clk) disable iff (!rst_n)
    step && nl_pend_r |-> line_w_r != '0)
    else $error("newline with wrapping disabled");

  // the buffer is never overwritten while holding unsent characters
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && grp_close && grp_valid_r |-> step && grp_done)
    else $error("group buffer overwritten");

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for base64_encoder_line_wrap (base64 encoding with line wrap).
// Drives bytes and line widths, predicts every character and compares each output request.
// Depends on b64lw_pkg and base64_encoder_line_wrap only.
module tb
  import b64lw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 6;
  localparam int RESET_TICKS = 12;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 10;
  localparam int TAIL_TICKS  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 300;
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One encoded character as it leaves the block
  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
  } enc_char_t;

  // One row of the directed stimulus; exp holds four typed characters when check is set
  typedef struct packed {
    bit          cfg;
    logic [15:0] width;
    logic [7:0]  data;
    bit          last;
    bit          check;
    logic [31:0] exp;
  } stim_row_t;

  localparam int N_ROWS = 26;
  stim_row_t directed_rows [N_ROWS] = '{
    '{1'b1, 16'd0,     8'h00, 1'b1, 1'b1, "AA=="},
    '{1'b0, 16'd0,     8'hFF, 1'b1, 1'b1, "/w=="},
    '{1'b0, 16'd0,     8'h00, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h00, 1'b1, 1'b1, "AAA="},
    '{1'b0, 16'd0,     8'hFF, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'hFF, 1'b1, 1'b1, "//8="},
    '{1'b0, 16'd0,     8'hFF, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'hFF, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'hFF, 1'b1, 1'b1, "////"},
    '{1'b0, 16'd0,     8'h00, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h00, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h00, 1'b1, 1'b1, "AAAA"},
    '{1'b0, 16'd0,     8'h4D, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h61, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h6E, 1'b0, 1'b1, "TWFu"},
    '{1'b0, 16'd0,     8'h4D, 1'b1, 1'b1, "TQ=="},
    // width one: newline after every character but the final one
    '{1'b1, 16'd1,     8'hFB, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'hEF, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'hBE, 1'b1, 1'b0, 32'h0},
    // open a line without wrap, then narrow the width mid-message
    '{1'b1, 16'd0,     8'h12, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h34, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h56, 1'b0, 1'b0, 32'h0},
    '{1'b1, 16'd3,     8'h78, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'h9A, 1'b0, 1'b0, 32'h0},
    '{1'b0, 16'd0,     8'hBC, 1'b1, 1'b0, 32'h0},
    '{1'b1, 16'hFFFF,  8'hA5, 1'b1, 1'b0, 32'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_char
  logic        out_tuser;  // run_end
  logic        out_tlast;  // message_end

  // Encoder shadow state
  logic [15:0]      width_shadow;
  logic [15:0]      pend_shadow;
  phase_t           phase_shadow;
  logic [COLUMN_BITS-1:0] column_shadow;

  enc_char_t step_chars[$];
  enc_char_t expected_chars[$];

  int snd_idle;
  int rcv_idle;
  int error_count;
  int items_sent;
  int cycle_count;
  int hold_left;
  logic hold_start;

  base64_encoder_line_wrap DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Append one character, advance the column and wrap when the line is full
  function automatic void add_char(input logic [7:0] c, input bit final_c);
    step_chars.insert(step_chars.size(), enc_char_t'{c, 1'b0, final_c});
    if (column_shadow != COL_MAX) column_shadow = column_shadow + 1'b1;
    if (!final_c && width_shadow != 16'd0 && column_shadow >= width_shadow) begin
      step_chars.insert(step_chars.size(), enc_char_t'{CHAR_NEWLINE, 1'b0, 1'b0});
      column_shadow = '0;
    end
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return B64_ALPHABET[s];
  endfunction

  // Encode one byte into step_chars and update the shadow state
  function automatic void encode_byte(input logic [7:0] b, input bit last);
    logic [23:0] word;
    step_chars.delete();
    if (phase_shadow == PHASE_TWO) begin
      word = {pend_shadow, b};
      add_char(sextet_char(word[23:18]), 1'b0);
      add_char(sextet_char(word[17:12]), 1'b0);
      add_char(sextet_char(word[11:6]), 1'b0);
      add_char(sextet_char(word[5:0]), last);
      pend_shadow  = '0;
      phase_shadow = PHASE_EMPTY;
    end else if (!last) begin
      if (phase_shadow == PHASE_EMPTY) begin
        pend_shadow  = {b, 8'h00};
        phase_shadow = PHASE_ONE;
      end else begin
        pend_shadow  = {pend_shadow[15:8], b};
        phase_shadow = PHASE_TWO;
      end
    end else if (phase_shadow == PHASE_ONE) begin
      word = {pend_shadow[15:8], b, 8'h00};
      add_char(sextet_char(word[23:18]), 1'b0);
      add_char(sextet_char(word[17:12]), 1'b0);
      add_char(sextet_char(word[11:6]), 1'b0);
      add_char(CHAR_PAD, 1'b1);
    end else begin
      word = {b, 16'h0000};
      add_char(sextet_char(word[23:18]), 1'b0);
      add_char(sextet_char(word[17:12]), 1'b0);
      add_char(CHAR_PAD, 1'b0);
      add_char(CHAR_PAD, 1'b1);
    end
    // close the message
    if (last) begin
      pend_shadow   = '0;
      phase_shadow  = PHASE_EMPTY;
      column_shadow = '0;
    end
    if (step_chars.size() != 0) step_chars[step_chars.size()-1].run_end = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one byte, hold it until accepted, then record its characters
  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    encode_byte(b, last);
    expected_chars = {expected_chars, step_chars};
    items_sent++;
  endtask

  // Drop the input and wait until every predicted character has been seen
  task automatic drain_output();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic set_width(input logic [15:0] w);
    drain_output();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    width_shadow = w;
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd3;
      4: return 16'd4;
      5: return 16'($urandom_range(5, 20));
      6: return 16'd76;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random messages, mostly short, with an occasional width change mid-message
  task automatic random_messages(input int count);
    int target;
    int len;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(3) == 0) set_width(pick_width());
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        send_byte(pick_byte(), i == len - 1);
        if (i != len - 1 && $urandom_range(19) == 0) set_width(pick_width());
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Compare each output request with the oldest prediction
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", out_tdata, 8'h00);
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== want.ch) report_mismatch("out_char", out_tdata, want.ch);
        if (out_tuser !== want.run_end)
          report_mismatch("run_end", {7'd0, out_tuser}, {7'd0, want.run_end});
        if (out_tlast !== want.msg_end)
          report_mismatch("message_end", {7'd0, out_tlast}, {7'd0, want.msg_end});
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    error_count   = 0;
    items_sent    = 0;
    cycle_count   = 0;
    width_shadow  = '0;
    pend_shadow   = '0;
    phase_shadow  = PHASE_EMPTY;
    column_shadow = '0;
    snd_idle      = 29;
    rcv_idle      = 84;
    hold_left     = 0;
    hold_start    <= 1'b0;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tlast      <= 1'b0;
    out_tready    <= 1'b0;
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: typed characters where given, predicted otherwise
    for (int r = 0; r < N_ROWS; r++) begin
      row = directed_rows[r];
      if (row.cfg) set_width(row.width);
      if (row.check) begin
        send_byte(row.data, row.last);
        repeat (step_chars.size()) void'(expected_chars.pop_back());
        for (int i = 0; i < 4; i++)
          expected_chars.insert(expected_chars.size(),
            enc_char_t'{row.exp[31-8*i -: 8], i == 3, row.last && i == 3});
      end else begin
        send_byte(row.data, row.last);
      end
    end

    // Hold the receiver off while a long message keeps arriving
    set_width(16'd5);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 24; i++) send_byte(pick_byte(), i == 23);

    random_messages(RAND_ITEMS / 3);
    snd_idle = 84;
    rcv_idle = 29;
    random_messages(RAND_ITEMS / 3);
    snd_idle = 0;
    rcv_idle = 0;
    random_messages(RAND_ITEMS / 3);

    drain_output();
    repeat (TAIL_TICKS) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
